// ----- hw/rtl/otp_pkg.sv -----
// shared types and constants of the one-shot timer pool
package otp_pkg;

  localparam int unsigned OpW   = 3;
  localparam int unsigned KindW = 2;
  localparam int unsigned DurW  = 32;
  localparam int unsigned TagW  = 8;
  localparam int unsigned TimeW = 32;

  typedef enum logic [OpW-1:0] {
    OP_TICK      = 3'd0,
    OP_INSERT    = 3'd1,
    OP_DELETE    = 3'd2,
    OP_FREE_ALL  = 3'd3,
    OP_INIT      = 3'd4,
    OP_READ_TIME = 3'd5
  } opcode_e;

  typedef enum logic [KindW-1:0] {
    KIND_INSERTED = 2'd0,
    KIND_NO_SLOT  = 2'd1,
    KIND_EXPIRED  = 2'd2,
    KIND_TIME     = 2'd3
  } kind_e;

  typedef enum logic [0:0] {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INC,
    ST_CMP,
    ST_EMIT,
    ST_INSERT,
    ST_READ
  } state_e;

endpackage

// ----- hw/rtl/otp_alu.sv -----
// shared add and compare unit of the timer pool
module otp_alu #(
  parameter int W = 32
) (
  input  otp_pkg::alu_op_e op_i,
  input  logic [W-1:0]     a_i,
  input  logic [W-1:0]     b_i,
  output logic [W-1:0]     res_o,
  output logic             carry_o
);
  import otp_pkg::*;

  logic [W-1:0] b_eff;
  logic         cin;

  // subtract is a plus inverted b plus one; carry out means a >= b
  always_comb begin
    b_eff = (op_i == ALU_SUB) ? ~b_i : b_i;
    cin   = (op_i == ALU_SUB);
    {carry_o, res_o} = {1'b0, a_i} + {1'b0, b_eff} + (W+1)'(cin);
  end

endmodule

// ----- hw/rtl/one_shot_timer_pool_top.sv -----
// Pool of one-shot timer slots driven by a tick count that advances once per
// tick operation. One operation is taken at a time; all time arithmetic
// (count increment, expiry add, expiry compare) goes through a single shared
// adder under a small sequencer. Delete, free all and init complete as they
// are accepted. Insert and read time then pass through their own state, which
// waits for the output register to be free. A tick increments the count, then
// compares every slot, one slot per cycle, then reports each expired slot in
// turn, waiting on the output for each. Expiries come out in slot order with
// tlast on the final one; a tick with no expiry gives no transfer. Results sit
// in an output register, so the next operation may be taken while the last
// result still waits.
module one_shot_timer_pool_top #(
  parameter  int SLOTS     = 3,
  parameter  int TIME_BITS = 32,
  localparam int SlotW     = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int InW       = ((otp_pkg::DurW + otp_pkg::TagW + SlotW + 7) / 8) * 8,
  localparam int OutW      = ((SlotW + otp_pkg::TagW + otp_pkg::TimeW + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [InW-1:0]              s_axis_tdata,  // duration, tag, slot
  input  logic [otp_pkg::OpW-1:0]     s_axis_tuser,  // opcode
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [OutW-1:0]             m_axis_tdata,  // slot_out, tag_out, time_out
  output logic [otp_pkg::KindW-1:0]   m_axis_tuser,  // kind
  output logic                        m_axis_tlast
);
  import otp_pkg::*;

  localparam logic [SlotW-1:0] LastIdx = SlotW'(SLOTS - 1);

  state_e                state_q, state_d;
  logic [TIME_BITS-1:0]  count_q, count_d;
  logic [SLOTS-1:0]      free_q, free_d;
  logic [SLOTS-1:0]      hit_q, hit_d;
  logic [SlotW-1:0]      idx_q, idx_d;
  logic [DurW-1:0]       dur_q;
  logic [TagW-1:0]       tag_in_q;
  logic [TIME_BITS-1:0]  expiry_q [SLOTS];
  logic [TagW-1:0]       tag_q [SLOTS];

  logic                  out_valid_q, out_valid_d;
  kind_e                 out_kind_q, out_kind_d;
  logic [SlotW-1:0]      out_slot_q, out_slot_d;
  logic [TagW-1:0]       out_tag_q, out_tag_d;
  logic [TimeW-1:0]      out_time_q, out_time_d;
  logic                  out_last_q, out_last_d;
  logic                  out_load, out_free;

  logic                  wr_en;
  logic [SlotW-1:0]      wr_idx;

  alu_op_e               alu_op;
  logic [TIME_BITS-1:0]  alu_a, alu_b, alu_res;
  logic                  alu_carry;

  logic                  accept;
  opcode_e               op_in;
  logic [DurW-1:0]       in_dur;
  logic [TagW-1:0]       in_tag;
  logic [SlotW-1:0]      in_slot;
  logic [SlotW-1:0]      free_idx, hit_idx;
  logic                  has_free, hit_single;

  function automatic logic [SlotW-1:0] lowest_set(input logic [SLOTS-1:0] v);
    logic [SlotW-1:0] r;
    r = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (v[i]) r = SlotW'(i);
    end
    return r;
  endfunction

  assign in_dur  = s_axis_tdata[DurW-1:0];
  assign in_tag  = s_axis_tdata[DurW +: TagW];
  assign in_slot = s_axis_tdata[DurW+TagW +: SlotW];
  assign op_in   = opcode_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign free_idx   = lowest_set(free_q);
  assign has_free   = |free_q;
  assign hit_idx    = lowest_set(hit_q);
  assign hit_single = ((hit_q & (hit_q - SLOTS'(1))) == '0);

  otp_alu #(
    .W (TIME_BITS)
  ) u_alu (
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .res_o   (alu_res),
    .carry_o (alu_carry)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_in)
            OP_TICK:      state_d = ST_INC;
            OP_INSERT:    state_d = ST_INSERT;
            OP_READ_TIME: state_d = ST_READ;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_INC: state_d = ST_CMP;
      ST_CMP: begin
        if (idx_q == LastIdx) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (hit_q == '0) state_d = ST_IDLE;
        else if (out_free && hit_single) state_d = ST_IDLE;
      end
      ST_INSERT: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_READ: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    alu_op     = ALU_SUB;
    alu_a      = count_q;
    alu_b      = expiry_q[idx_q];
    count_d    = count_q;
    free_d     = free_q;
    hit_d      = hit_q;
    idx_d      = idx_q;
    wr_en      = 1'b0;
    wr_idx     = free_idx;
    out_load   = 1'b0;
    out_kind_d = KIND_INSERTED;
    out_slot_d = '0;
    out_tag_d  = '0;
    out_time_d = '0;
    out_last_d = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_in)
            OP_TICK: begin
              idx_d = '0;
              hit_d = '0;
            end
            OP_DELETE: begin
              if ({1'b0, in_slot} < (SlotW+1)'(SLOTS)) free_d[in_slot] = 1'b1;
            end
            OP_FREE_ALL: free_d = '1;
            OP_INIT: begin
              count_d = '0;
              free_d  = '1;
            end
            default: ;
          endcase
        end
      end
      ST_INC: begin
        alu_op  = ALU_ADD;
        alu_b   = TIME_BITS'(1);
        count_d = alu_res;
      end
      ST_CMP: begin
        // count >= expiry of a live slot
        if (!free_q[idx_q] && alu_carry) begin
          hit_d[idx_q]  = 1'b1;
          free_d[idx_q] = 1'b1;
        end
        if (idx_q != LastIdx) idx_d = SlotW'(idx_q + 1'b1);
      end
      ST_EMIT: begin
        if (hit_q != '0 && out_free) begin
          out_load       = 1'b1;
          out_kind_d     = KIND_EXPIRED;
          out_slot_d     = hit_idx;
          out_tag_d      = tag_q[hit_idx];
          out_last_d     = hit_single;
          hit_d[hit_idx] = 1'b0;
        end
      end
      ST_INSERT: begin
        alu_op = ALU_ADD;
        alu_b  = TIME_BITS'(dur_q);
        if (out_free) begin
          out_load = 1'b1;
          if (has_free) begin
            wr_en            = 1'b1;
            free_d[free_idx] = 1'b0;
            out_kind_d       = KIND_INSERTED;
            out_slot_d       = free_idx;
          end else begin
            out_kind_d = KIND_NO_SLOT;
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = KIND_TIME;
          out_time_d = TimeW'(count_q);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      free_q      <= '1;
      hit_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      free_q      <= free_d;
      hit_q       <= hit_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dur_q    <= in_dur;
      tag_in_q <= in_tag;
    end
    if (wr_en) begin
      expiry_q[wr_idx] <= alu_res;
      tag_q[wr_idx]    <= tag_in_q;
    end
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_slot_q <= out_slot_d;
      out_tag_q  <= out_tag_d;
      out_time_q <= out_time_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = OutW'({out_time_q, out_tag_q, out_slot_q});

  // pending expiries were already freed during the compare pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit_q & ~free_q) == '0)
    else $error("pending expiry on a live slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q == ST_INC) && !(accept && op_in == OP_INIT) |=> $stable(count_q))
    else $error("tick count changed outside increment or init");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_load && hit_single) |=> (hit_q == '0 && state_q == ST_IDLE))
    else $error("expiry pass did not finish on last transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_in == OP_TICK) |=> (state_q == ST_INC && hit_q == '0))
    else $error("tick did not start a clean compare pass");

endmodule
